@@ design/dirty_slot_write_throttle_top_assert.svh @@
// Assertion macros for the dirty slot write throttle checker.
// Expects signals named clk and arst_n in the scope of use.
`ifndef DIRTY_SLOT_WRITE_THROTTLE_TOP_ASSERT_SVH
`define DIRTY_SLOT_WRITE_THROTTLE_TOP_ASSERT_SVH

// same-cycle implication
`define DSWT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dswt assertion failed");

// next-cycle implication
`define DSWT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dswt assertion failed");

`endif

@@ design/dswt_pkg.sv @@
// Shared types and constants for the dirty slot write throttle.
// No dependencies.
`default_nettype none

package dswt_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int SLOT_W        = 8;
	localparam int TIME_W        = 32;
	localparam int REQ_W         = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_QUERY = 2'd0,
		REQ_MARK  = 2'd1,
		REQ_WRITE = 2'd2
	} req_code_t;

	// request broadcast to every cell
	typedef struct packed {
		logic              upd;
		logic [REQ_W-1:0]  req_type;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] now_time;
		logic              force_req;
		logic [TIME_W-1:0] min_interval;
	} cmd_t;

	// partial result handed from cell to cell
	typedef struct packed {
		logic any_due;
		logic slot_due;
		logic slot_dirty;
	} link_t;

endpackage

`default_nettype wire

@@ design/dswt_cell.sv @@
// One slot of the throttle: dirty/written marks, last write time, and
// one stage of the due-sweep chain. Depends on dswt_pkg.
`default_nettype none

module dswt_cell #(
	parameter logic [dswt_pkg::SLOT_W-1:0] IDX = '0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  dswt_pkg::cmd_t      cmd,
	input  dswt_pkg::link_t     link_in,
	output dswt_pkg::link_t     link_out
);
	import dswt_pkg::*;

	logic              dirty_q;
	logic              written_q;
	logic [TIME_W-1:0] last_time_q;
	link_t             link_q;
	logic              hit;
	logic              due;
	logic [TIME_W-1:0] elapsed;

	assign hit     = (cmd.slot == IDX);
	assign elapsed = cmd.now_time - last_time_q;
	assign due     = dirty_q && (cmd.force_req || !written_q || (elapsed >= cmd.min_interval));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q   <= 1'b0;
			written_q <= 1'b0;
		end else if (cmd.upd && hit) begin
			case (cmd.req_type)
				REQ_MARK: begin
					dirty_q <= 1'b1;
				end
				REQ_WRITE: begin
					dirty_q   <= 1'b0;
					written_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd && hit && cmd.req_type == REQ_WRITE) begin
			last_time_q <= cmd.now_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q.any_due    <= link_in.any_due | due;
			link_q.slot_due   <= link_in.slot_due | (hit & due);
			link_q.slot_dirty <= link_in.slot_dirty | (hit & dirty_q);
		end
	end

	assign link_out = link_q;

endmodule

`default_nettype wire

@@ design/dirty_slot_write_throttle_top.sv @@
// Top level of the dirty slot write throttle: request latch, sequencer,
// APB register and the chain of dswt_cell slots. Depends on dswt_pkg.
//
// Usage:
//   Requests: drive req_type, slot, now_time, force_req and pulse start;
//   the transaction is taken at a clock edge with start high and busy low.
//   busy stays high until the result is shown.
//   Results: done is high for exactly one cycle with slot_due, slot_dirty,
//   any_due and slot_ok valid in that cycle. The receiver cannot stall.
//   Timing: after acceptance upd_q applies the slot update, then the due
//   check ripples through the cell chain one cell per cycle. done rises
//   when the sweep has passed the last cell; busy drops together with
//   done, so a new request can be taken in the done cycle but not
//   before it: only one request is in flight at a time.
//   Configuration: min_interval at byte address 0 over APB; write only
//   while idle. pready is tied high.
//   Reset: all slots clean and never written, min_interval zero, idle.
`default_nettype none

module dirty_slot_write_throttle_top #(
	parameter int NUM_SLOTS = dswt_pkg::NUM_SLOTS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  [dswt_pkg::REQ_W-1:0]   req_type,
	input  wire  [dswt_pkg::SLOT_W-1:0]  slot,
	input  wire  [dswt_pkg::TIME_W-1:0]  now_time,
	input  wire                          force_req,
	output logic                         done,
	output logic                         slot_due,
	output logic                         slot_dirty,
	output logic                         any_due,
	output logic                         slot_ok,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [2:0]                   paddr,
	input  wire  [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import dswt_pkg::*;

	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_SLOTS - 1);

	logic                   busy_q;
	logic                   upd_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [REQ_W-1:0]       req_type_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [TIME_W-1:0]      now_time_q;
	logic                   force_req_q;
	logic [TIME_W-1:0]      min_interval_q;
	logic                   accept;
	logic                   reg_sel;
	cmd_t                   cmd;
	link_t                  chain [NUM_SLOTS+1];

	assign accept  = start && !busy_q;
	assign reg_sel = (paddr[2] == 1'b0);

	// APB register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			min_interval_q <= pwdata;
		end
	end

	assign prdata = reg_sel ? min_interval_q : '0;
	assign pready = 1'b1;

	// request latch
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q  <= req_type;
			slot_q      <= slot;
			now_time_q  <= now_time;
			force_req_q <= force_req;
		end
	end

	// sequencer: slot update first, then a counted sweep through the cell chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				busy_q <= 1'b1;
				upd_q  <= 1'b1;
				cnt_q  <= '0;
			end else if (upd_q) begin
				upd_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign cmd.upd          = upd_q;
	assign cmd.req_type     = req_type_q;
	assign cmd.slot         = slot_q;
	assign cmd.now_time     = now_time_q;
	assign cmd.force_req    = force_req_q;
	assign cmd.min_interval = min_interval_q;

	assign chain[0] = '0;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		dswt_cell #(
			.IDX(SLOT_W'(i))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.link_in  (chain[i]),
			.link_out (chain[i+1])
		);
	end

	assign busy       = busy_q;
	assign done       = done_q;
	assign slot_due   = chain[NUM_SLOTS].slot_due;
	assign slot_dirty = chain[NUM_SLOTS].slot_dirty;
	assign any_due    = chain[NUM_SLOTS].any_due;
	assign slot_ok    = (slot_q < SLOT_W'(NUM_SLOTS));

endmodule

`default_nettype wire

@@ design/dswt_chk.sv @@
// Port-level checker for dirty_slot_write_throttle_top, bound to the top.
// Depends on dirty_slot_write_throttle_top_assert.svh.
`default_nettype none

`include "dirty_slot_write_throttle_top_assert.svh"

module dswt_chk (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire done,
	input wire slot_due,
	input wire slot_dirty,
	input wire any_due,
	input wire slot_ok
);

	`DSWT_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done)
	`DSWT_ASSERT_IMP(a_done_idle, done, !busy)
	`DSWT_ASSERT_NXT(a_done_single, done, !done)
	`DSWT_ASSERT_IMP(a_bad_slot_quiet, done && !slot_ok, !slot_due && !slot_dirty)
	`DSWT_ASSERT_IMP(a_due_dirty, done && slot_due, slot_dirty && any_due)

endmodule

bind dirty_slot_write_throttle_top dswt_chk u_dswt_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.slot_due   (slot_due),
	.slot_dirty (slot_dirty),
	.any_due    (any_due),
	.slot_ok    (slot_ok)
);

`default_nettype wire

@@ test/dirty_slot_write_throttle_top_tb.sv @@
// Self-checking testbench for dirty_slot_write_throttle_top: directed table, then random requests.
// Uses dswt_pkg for the request codes and the slot count; needs nothing but the RTL.
`default_nettype none

module dirty_slot_write_throttle_top_tb;
	import dswt_pkg::*;

	localparam int SLOTS = NUM_SLOTS_DEF;
	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
	localparam logic [2:0] ADDR_MIN_INTERVAL = 3'd0;
	localparam logic [2:0] ADDR_UNUSED       = 3'd4;
	localparam int LIMIT = 200000;

	typedef struct packed {
		logic slot_due;
		logic slot_dirty;
		logic any_due;
		logic slot_ok;
	} throttle_res_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] now;
		logic              frc;
		logic              chk;
		throttle_res_t     want;
	} throttle_req_t;

	// fixed rows: expected result typed in where chk is set, otherwise predicted
	localparam int N_DIR = 13;
	localparam throttle_req_t DIR_TAB [N_DIR] = '{
		'{REQ_QUERY, 8'd0,   32'd0,          1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1}},
		'{REQ_QUERY, 8'd255, 32'hFFFF_FFFF,  1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0}},
		'{REQ_MARK,  8'd16,  32'd0,          1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0}},
		'{REQ_MARK,  8'd0,   32'd0,          1'b0, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b1}},
		'{REQ_WRITE, 8'd0,   32'd5,          1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1}},
		'{REQ_MARK,  8'd15,  32'hFFFF_FFFF,  1'b1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b1}},
		'{REQ_WRITE, 8'd15,  32'hFFFF_FFFF,  1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1}},
		'{REQ_MARK,  8'd15,  32'd0,          1'b0, 1'b0, '0},
		'{REQ_SPARE, 8'd15,  32'd0,          1'b0, 1'b0, '0},
		'{REQ_QUERY, 8'd0,   32'd3,          1'b1, 1'b0, '0},
		'{REQ_WRITE, 8'd200, 32'd7,          1'b0, 1'b0, '0},
		'{REQ_MARK,  8'd0,   32'd2,          1'b1, 1'b0, '0},
		'{REQ_WRITE, 8'd15,  32'd9,          1'b0, 1'b0, '0}
	};

	logic              clk;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [REQ_W-1:0]  req_type = '0;
	logic [SLOT_W-1:0] slot = '0;
	logic [TIME_W-1:0] now_time = '0;
	logic              force_req = 1'b0;
	logic              done;
	logic              slot_due;
	logic              slot_dirty;
	logic              any_due;
	logic              slot_ok;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	dirty_slot_write_throttle_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .slot(slot), .now_time(now_time), .force_req(force_req),
		.done(done), .slot_due(slot_due), .slot_dirty(slot_dirty), .any_due(any_due),
		.slot_ok(slot_ok), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic              dirty_m   [SLOTS];
	logic              written_m [SLOTS];
	logic [TIME_W-1:0] wr_time   [SLOTS];
	logic [TIME_W-1:0] min_int_cfg;

	throttle_req_t pending_req [$];
	throttle_res_t due_expect [$];
	throttle_req_t cur_req;
	throttle_res_t pred;
	throttle_res_t exp_res;
	logic          taken;
	int            idle_pct = 0;
	int            n_pushed = 0;
	int            n_accepted = 0;
	int            n_results = 0;
	int            n_settings = 0;
	int            errors = 0;
	int unsigned   cyc = 0;
	logic [TIME_W-1:0] tick = '0;

	function automatic logic due_now(input int idx, input logic [TIME_W-1:0] now,
			input logic frc);
		if (idx >= SLOTS || !dirty_m[idx])
			return 1'b0;
		if (frc || !written_m[idx])
			return 1'b1;
		return (now - wr_time[idx]) >= min_int_cfg;
	endfunction

	function automatic throttle_res_t apply_request(input throttle_req_t r);
		throttle_res_t o;
		logic in_range;
		int i;
		in_range = r.slot < SLOTS;
		if (in_range) begin
			if (r.req == REQ_MARK) begin
				dirty_m[r.slot] = 1'b1;
			end else if (r.req == REQ_WRITE) begin
				dirty_m[r.slot] = 1'b0;
				written_m[r.slot] = 1'b1;
				wr_time[r.slot] = r.now;
			end
		end
		o.any_due = 1'b0;
		for (i = 0; i < SLOTS; i++)
			if (due_now(i, r.now, r.frc))
				o.any_due = 1'b1;
		o.slot_due = in_range ? due_now(r.slot, r.now, r.frc) : 1'b0;
		o.slot_dirty = in_range ? dirty_m[r.slot] : 1'b0;
		o.slot_ok = in_range;
		return o;
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned seen,
			input int unsigned want);
		$display("MISMATCH @%0t: %s: got %0h, want %0h", $time, what, seen, want);
		errors++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("** dirty_slot_write_throttle_top: FAILED **");
			$finish;
		end
	end

	// request driver: one transaction in flight, start held until taken
	always @(posedge clk) begin
		if (arst_n) begin
			taken = start && !busy;
			if (taken) begin
				pred = apply_request(cur_req);
				due_expect.push_back(cur_req.chk ? cur_req.want : pred);
				n_accepted++;
			end
			if (!start || taken) begin
				if (pending_req.size() != 0 && $urandom_range(99) >= idle_pct) begin
					cur_req = pending_req.pop_front();
					req_type <= cur_req.req;
					slot <= cur_req.slot;
					now_time <= cur_req.now;
					force_req <= cur_req.frc;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_expect.size() == 0) begin
				flag_mismatch("result with nothing expected", 1, 0);
			end else begin
				exp_res = due_expect.pop_front();
				if (slot_due !== exp_res.slot_due)
					flag_mismatch("slot_due", slot_due, exp_res.slot_due);
				if (slot_dirty !== exp_res.slot_dirty)
					flag_mismatch("slot_dirty", slot_dirty, exp_res.slot_dirty);
				if (any_due !== exp_res.any_due)
					flag_mismatch("any_due", any_due, exp_res.any_due);
				if (slot_ok !== exp_res.slot_ok)
					flag_mismatch("slot_ok", slot_ok, exp_res.slot_ok);
				n_results++;
			end
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_MIN_INTERVAL)
			min_int_cfg = data;
	endtask

	task automatic apb_read_check;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= ADDR_MIN_INTERVAL;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== min_int_cfg)
			flag_mismatch("min_interval readback", prdata, min_int_cfg);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_interval(input logic [31:0] val);
		apb_write(ADDR_MIN_INTERVAL, val);
		apb_read_check();
		n_settings++;
	endtask

	// wait until every transaction is taken and answered, then let the chain settle
	task automatic drain;
		while (n_accepted < n_pushed || due_expect.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random(input int count, input int unsigned step, input int pct);
		throttle_req_t r;
		int k;
		idle_pct = pct;
		repeat (count) begin
			while (pending_req.size() >= 2)
				@(posedge clk);
			k = $urandom_range(99);
			r.req = k < 40 ? REQ_MARK : k < 70 ? REQ_WRITE : k < 95 ? REQ_QUERY : REQ_SPARE;
			k = $urandom_range(99);
			r.slot = SLOT_W'(k < 85 ? $urandom_range(SLOTS - 1) : $urandom_range(255, SLOTS));
			k = $urandom_range(99);
			if (k < 10) begin
				r.now = $urandom;
			end else if (k < 22 && r.slot < SLOTS) begin
				// land on either side of the interval boundary
				r.now = wr_time[r.slot] + min_int_cfg - $urandom_range(1);
			end else begin
				tick = tick + $urandom_range(step);
				r.now = tick;
			end
			r.frc = $urandom_range(99) < 20;
			r.chk = 1'b0;
			r.want = '0;
			pending_req.push_back(r);
			n_pushed++;
		end
		drain();
	endtask

	initial begin
		int i;
		for (i = 0; i < SLOTS; i++) begin
			dirty_m[i] = 1'b0;
			written_m[i] = 1'b0;
			wr_time[i] = '0;
		end
		min_int_cfg = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_read_check();
		set_interval(32'd0);

		idle_pct = 0;
		for (i = 0; i < N_DIR; i++) begin
			pending_req.push_back(DIR_TAB[i]);
			n_pushed++;
		end
		drain();

		run_random(150, 20, 0);
		set_interval(32'd100);
		run_random(200, 60, 50);
		set_interval(32'd7);
		run_random(150, 5, 15);
		set_interval(32'hFFFF_FFFF);
		run_random(100, 3, 0);
		// write to an unmapped register must leave min_interval alone
		apb_write(ADDR_UNUSED, $urandom);
		apb_read_check();
		set_interval(32'd1000);
		run_random(150, 400, 50);
		set_interval(32'h8000_0000);
		run_random(50, 1000, 15);

		repeat (30) @(posedge clk);
		if (due_expect.size() != 0)
			flag_mismatch("results still expected at end", 0, due_expect.size());

		$display("Covered %0d requests (%0d results) over %0d min_interval settings,",
			n_accepted, n_results, n_settings);
		$display("with bursty and back-to-back request timing; %0d mismatches.", errors);
		if (errors == 0) begin
			$display("** dirty_slot_write_throttle_top: PASSED **");
		end else begin
			$display("** dirty_slot_write_throttle_top: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/dswt_pkg.sv
design/dswt_cell.sv
design/dirty_slot_write_throttle_top.sv
design/dswt_chk.sv
test/dirty_slot_write_throttle_top_tb.sv
